FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// Needs only a label, a clock, an active-low reset and two boolean expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/sfcc_pkg.sv
// Shared types, constants and helpers of the sensor frame CRC checker.
// No dependencies.
`default_nettype none

package sfcc_pkg;

  localparam int unsigned FrameLengthDefault = 8;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8005;

  // Magnetometer header, bytes 1 to 3
  localparam logic [7:0] HdrByte1 = 8'hAB;
  localparam logic [7:0] HdrByte2 = 8'h00;
  localparam logic [7:0] HdrByte3 = 8'h28;

  typedef struct packed {
    logic        crc_good;
    logic        info_updated;
    logic [15:0] mag_value;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfcc_crc.sv
// Byte-wide CRC-16 step (poly 0x8005, MSB-first register, byte fed reversed).
// Depends on sfcc_pkg.
`default_nettype none

module sfcc_crc import sfcc_pkg::*; (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  logic [15:0] c;

  always_comb begin
    c = crc_i ^ {rev8(byte_i), 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfcc_frame.sv
// Frame tracker: byte position, running CRC, header match, value capture.
// Updates on step_i; result_valid_o/result_o show what that step produces.
// Depends on sfcc_pkg and sfcc_crc.
`default_nettype none

module sfcc_frame import sfcc_pkg::*; #(
  parameter int unsigned FrameLength = FrameLengthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_start_i,
  output logic            result_valid_o,
  output result_t         result_o
);

  localparam int unsigned PosW = $clog2(FrameLength + 1);
  localparam logic [PosW-1:0] PosIdle    = PosW'(FrameLength);
  localparam logic [PosW-1:0] PosTrlLow  = PosW'(FrameLength - 2);
  localparam logic [PosW-1:0] PosTrlHigh = PosW'(FrameLength - 1);
  localparam logic [PosW-1:0] Pos1 = PosW'(1);
  localparam logic [PosW-1:0] Pos2 = PosW'(2);
  localparam logic [PosW-1:0] Pos3 = PosW'(3);
  localparam logic [PosW-1:0] Pos4 = PosW'(4);
  localparam logic [PosW-1:0] Pos5 = PosW'(5);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]     crc_q, crc_d, crc_eff, crc_next;
  logic            hdr_q, hdr_d, hdr_eff;
  logic [15:0]     pend_q, pend_d;
  logic [7:0]      trl_q, trl_d;
  logic [15:0]     held_q, held_d;
  logic            good, upd;

  // frame_start restarts before the byte is looked at
  assign pos_eff = frame_start_i ? '0 : pos_q;
  assign crc_eff = frame_start_i ? CrcInit : crc_q;
  assign hdr_eff = frame_start_i ? 1'b0 : hdr_q;

  sfcc_crc u_crc (
    .crc_i  (crc_eff),
    .byte_i (data_byte_i),
    .crc_o  (crc_next)
  );

  assign good = (rev16(crc_eff) == {data_byte_i, trl_q});
  assign upd  = good && hdr_eff;

  always_comb begin
    pos_d          = pos_q;
    crc_d          = crc_q;
    hdr_d          = hdr_q;
    pend_d         = pend_q;
    trl_d          = trl_q;
    held_d         = held_q;
    result_valid_o = 1'b0;
    if (step_i) begin
      pos_d = pos_eff;
      crc_d = crc_eff;
      hdr_d = hdr_eff;
      if (pos_eff < PosTrlLow) begin
        crc_d = crc_next;
        if (pos_eff == Pos1) begin
          hdr_d = (data_byte_i == HdrByte1);
        end else if (pos_eff == Pos2) begin
          hdr_d = hdr_eff && (data_byte_i == HdrByte2);
        end else if (pos_eff == Pos3) begin
          hdr_d = hdr_eff && (data_byte_i == HdrByte3);
        end else if (pos_eff == Pos4) begin
          pend_d = {data_byte_i, pend_q[7:0]};
        end else if (pos_eff == Pos5) begin
          pend_d = {pend_q[15:8], data_byte_i};
        end
        pos_d = pos_eff + PosW'(1);
      end else if (pos_eff == PosTrlLow) begin
        trl_d = data_byte_i;
        pos_d = pos_eff + PosW'(1);
      end else if (pos_eff == PosTrlHigh) begin
        result_valid_o = 1'b1;
        if (upd) begin
          held_d = pend_q;
        end
        pos_d = PosIdle;
      end
    end
  end

  assign result_o.crc_good     = good;
  assign result_o.info_updated = upd;
  assign result_o.mag_value    = upd ? pend_q : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosIdle;
      crc_q  <= CrcInit;
      hdr_q  <= 1'b0;
      pend_q <= '0;
      trl_q  <= '0;
      held_q <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      hdr_q  <= hdr_d;
      pend_q <= pend_d;
      trl_q  <= trl_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sensor_frame_crc_checker_core.sv
// Sensor frame CRC checker, top level.
// Input channel: in_valid_i/in_stall_o carry one frame byte per item
// (data_byte_i, frame_start_i). An item is taken on a rising edge with
// in_valid_i high and in_stall_o low. frame_start_i marks byte 0 and
// restarts the frame; bytes outside a frame are dropped.
// Output channel: out_valid_o/out_stall_i, one item per complete frame with
// crc_good_o, info_updated_o and mag_value_o (held sensor value).
// CRC-16/MODBUS over all but the last two bytes; trailer is low byte first.
// Structure: an input register, the frame logic, a result register.
// A taken byte waits in the input register until the frame logic steps on
// it; the last byte's result is registered and then shows on out_valid_o.
// Throughput is one byte per cycle while no pending result is stalled.
// When the receiver stalls a pending result, the frame logic holds and the
// input register fills, after which in_stall_o rises.
// Reset (rst_ni, async low) empties both registers, makes the tracker idle
// and clears the held value to zero.
`default_nettype none

module sensor_frame_crc_checker_core import sfcc_pkg::*; #(
  parameter int unsigned FrameLength = FrameLengthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             crc_good_o,
  output logic             info_updated_o,
  output logic [15:0]      mag_value_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance, accept;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // Hold the frame logic while a finished result waits downstream
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  sfcc_frame #(
    .FrameLength (FrameLength)
  ) u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .data_byte_i    (byte_q),
    .frame_start_i  (start_q),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign crc_good_o     = out_q.crc_good;
  assign info_updated_o = out_q.info_updated;
  assign mag_value_o    = out_q.mag_value;

endmodule

`default_nettype wire

FILE: hw/rtl/sfcc_checker.sv
// Port-level checks for the sensor frame CRC checker, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        crc_good_o,
  input wire logic        info_updated_o,
  input wire logic [15:0] mag_value_o
);

  logic [17:0] payload;

  assign payload = {crc_good_o, info_updated_o, mag_value_o};

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // and keeps its payload
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(payload))

  // An update needs a good CRC
  `ASSERT_IMPLY(a_upd_good, clk_i, rst_ni, out_valid_o && info_updated_o, crc_good_o)

  // Frames are FrameLength bytes, eight by default, so results never follow back to back
  `ASSERT_NEXT(a_no_b2b, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)

endmodule

bind sensor_frame_crc_checker_core sfcc_checker u_sfcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .crc_good_o     (crc_good_o),
  .info_updated_o (info_updated_o),
  .mag_value_o    (mag_value_o)
);

`default_nettype wire

FILE: verif/tb_sensor_frame_crc_checker_core.sv
// Testbench for sensor_frame_crc_checker_core: directed frames, then random frame traffic,
// with random stalls on both channels. Results are checked against a CRC-16/MODBUS frame tracker.
// Depends on sfcc_pkg and the core RTL only.
module tb_sensor_frame_crc_checker_core import sfcc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN = FrameLengthDefault;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned QUIET_FROM = 700;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // 0x8005 bit-reversed, for the LSB-first form of the CRC
  localparam logic [15:0] CrcPolyReflected = 16'hA001;

  // How a trailer byte is filled in: as written, correct CRC byte, or its complement
  typedef enum logic [1:0] {TRL_AS_IS, TRL_GOOD, TRL_BAD} trailer_fill_e;

  typedef struct {
    logic [7:0]    b;
    logic          s;
    trailer_fill_e fill;
    logic          typed;
    result_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        crc_good;
  logic        info_updated;
  logic [15:0] mag_value;

  // Frame tracker state
  logic [15:0] trk_crc = CrcInit;
  int unsigned trk_pos = FRAME_LEN;
  logic        trk_hdr = 1'b0;
  logic [15:0] trk_pend = 16'h0000;
  logic [7:0]  trk_trl_lo = 8'h00;
  logic [15:0] trk_held = 16'h0000;

  result_t     frame_reports_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent_count = 0;
  int unsigned gap_odds = 0;    // 0: no idling, else 1 in gap_odds
  int unsigned stall_odds = 0;
  logic        hold_req = 1'b0;

  stim_row_t directed_tbl [28] = '{
    // idle byte after reset
    '{8'hFF, 1'b0, TRL_AS_IS, 1'b0, '0},
    // magnetometer frame, value 0xFFFF, good CRC
    '{8'h00, 1'b1, TRL_AS_IS, 1'b0, '0},
    '{8'hAB, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h28, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'hFF, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'hFF, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_GOOD,  1'b0, '0},
    '{8'h00, 1'b0, TRL_GOOD,  1'b1, '{1'b1, 1'b1, 16'hFFFF}},
    // partial frame, dropped by the restart below
    '{8'h55, 1'b1, TRL_AS_IS, 1'b0, '0},
    '{8'hAB, 1'b0, TRL_AS_IS, 1'b0, '0},
    // magnetometer frame with bad CRC: held value stays
    '{8'hAA, 1'b1, TRL_AS_IS, 1'b0, '0},
    '{8'hAB, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h28, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_GOOD,  1'b0, '0},
    '{8'h00, 1'b0, TRL_BAD,   1'b1, '{1'b0, 1'b0, 16'hFFFF}},
    // idle byte after a complete frame
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    // other header, good CRC
    '{8'hFF, 1'b1, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'hFF, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h28, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h12, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h34, 1'b0, TRL_AS_IS, 1'b0, '0},
    '{8'h00, 1'b0, TRL_GOOD,  1'b0, '0},
    '{8'h00, 1'b0, TRL_GOOD,  1'b1, '{1'b1, 1'b0, 16'hFFFF}}
  };

  sensor_frame_crc_checker_core #(
    .FrameLength(FRAME_LEN)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .crc_good_o    (crc_good),
    .info_updated_o(info_updated),
    .mag_value_o   (mag_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // LSB-first CRC-16/MODBUS over one byte
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyReflected) : (c >> 1);
    end
    return c;
  endfunction

  // Advances the frame tracker by one byte; returns 1 when the byte closes a frame
  function automatic logic check_frame_byte(input logic [7:0] b, input logic s,
                                            output result_t r);
    logic [15:0] trailer;
    r = '0;
    if (s) begin
      trk_pos = 0;
      trk_crc = CrcInit;
      trk_hdr = 1'b0;
    end
    if (trk_pos >= FRAME_LEN) return 1'b0;
    if (trk_pos < FRAME_LEN - 2) begin
      trk_crc = modbus_crc_byte(trk_crc, b);
      case (trk_pos)
        1: trk_hdr = (b == HdrByte1);
        2: trk_hdr = trk_hdr && (b == HdrByte2);
        3: trk_hdr = trk_hdr && (b == HdrByte3);
        4: trk_pend[15:8] = b;
        5: trk_pend[7:0] = b;
        default: ;
      endcase
      trk_pos++;
      return 1'b0;
    end
    if (trk_pos == FRAME_LEN - 2) begin
      trk_trl_lo = b;
      trk_pos++;
      return 1'b0;
    end
    trailer = {b, trk_trl_lo};
    r.crc_good = (trailer == trk_crc);
    r.info_updated = r.crc_good && trk_hdr;
    if (r.info_updated) trk_held = trk_pend;
    r.mag_value = trk_held;
    trk_pos = FRAME_LEN;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  // Offers one byte, waits for it to be taken, then maybe idles a burst
  task automatic send_item(input logic [7:0] b, input logic s, input trailer_fill_e fill,
                           input logic typed, input result_t want);
    logic [7:0] v;
    result_t    r;
    v = b;
    if (fill != TRL_AS_IS) begin
      v = (trk_pos == FRAME_LEN - 2) ? trk_crc[7:0] : trk_crc[15:8];
      if (fill == TRL_BAD) v = ~v;
    end
    in_valid <= 1'b1;
    data_byte <= v;
    frame_start <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (check_frame_byte(v, s, r)) frame_reports_q.push_back(typed ? want : r);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_random_frame();
    logic [7:0]    fb [FRAME_LEN];
    logic [15:0]   val;
    int unsigned   kind;
    int unsigned   stop_at;
    trailer_fill_e lo_fill;
    trailer_fill_e hi_fill;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // stray bytes with no start flag
      repeat ($urandom_range(1, 3))
        send_item(8'($urandom_range(0, 255)), 1'b0, TRL_AS_IS, 1'b0, '0);
      return;
    end
    foreach (fb[i]) fb[i] = 8'($urandom_range(0, 255));
    fb[1] = HdrByte1;
    fb[2] = HdrByte2;
    fb[3] = HdrByte3;
    if ($urandom_range(0, 3) == 0) fb[$urandom_range(1, 3)] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: val = 16'h0000;
      1: val = 16'hFFFF;
      default: val = 16'($urandom_range(0, 16'hFFFF));
    endcase
    fb[4] = val[15:8];
    fb[5] = val[7:0];
    // truncated frame: the next start flag cuts it off
    stop_at = (kind <= 2) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    lo_fill = TRL_GOOD;
    hi_fill = TRL_GOOD;
    if (kind == 3) begin
      lo_fill = TRL_AS_IS;
      hi_fill = TRL_AS_IS;
    end else if (kind == 4) begin
      hi_fill = TRL_BAD;
    end else if (kind == 5) begin
      lo_fill = TRL_BAD;
    end
    for (int unsigned i = 0; i < stop_at; i++) begin
      send_item(fb[i], i == 0,
                (i == FRAME_LEN - 2) ? lo_fill : (i == FRAME_LEN - 1) ? hi_fill : TRL_AS_IS,
                1'b0, '0);
      sent_count++;
    end
  endtask

  // Result receiver: random stall bursts, and one long hold on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_reports_q.size() == 0) begin
        $error("frame report with no frame pending");
        mismatches++;
      end else begin
        want = frame_reports_q.pop_front();
        compare_field("crc_good", 16'(want.crc_good), 16'(crc_good));
        compare_field("info_updated", 16'(want.info_updated), 16'(info_updated));
        compare_field("mag_value", want.mag_value, mag_value);
      end
    end
  end

  initial begin
    int unsigned frame_no;
    logic        late;
    frame_no = 0;
    late = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_odds = 3;
    stall_odds = 3;
    foreach (directed_tbl[i]) begin
      send_item(directed_tbl[i].b, directed_tbl[i].s, directed_tbl[i].fill,
                directed_tbl[i].typed, directed_tbl[i].want);
    end

    while (sent_count < RANDOM_ITEMS) begin
      if (!late && frame_no % 10 == 0) begin
        gap_odds = pick_odds();
        stall_odds = pick_odds();
      end
      if (frame_no == 25) begin
        // back-to-back bytes against a long receiver hold fill the pipe
        gap_odds = 0;
        hold_req = 1'b1;
      end
      if (frame_no == 60) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_reports_q.size() != 0) @(posedge clk);
      end
      if (!late && sent_count >= QUIET_FROM) begin
        late = 1'b1;
        gap_odds = 0;
        stall_odds = 0;
      end
      send_random_frame();
      frame_no++;
    end

    in_valid <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sfcc_pkg.sv
hw/rtl/sfcc_crc.sv
hw/rtl/sfcc_frame.sv
hw/rtl/sensor_frame_crc_checker_core.sv
hw/rtl/sfcc_checker.sv
verif/tb_sensor_frame_crc_checker_core.sv
